### sv/rsi_pkg.sv
// Shared types and constants for the relative strength index unit.
// No dependencies; compiled first.
`default_nettype none

package rsi_pkg;

  localparam int PRICE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int PRICE_IN_W = 32;
  localparam int RSI_W      = 23;
  localparam int PERIOD_W   = 8;
  localparam int GUARD_BITS = 8;
  localparam int RSI_SCALE  = 100;
  localparam int SCALE_BITS = 7;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 8'd2;
  localparam logic [PERIOD_W-1:0] WARM_DONE    = 8'hFF;

  typedef struct packed {
    logic take;
    logic acc;
    logic seed_ld;
    logic mul;
    logic add;
    logic div_step;
    logic wb;
    logic wb_seed;
    logic rmul;
    logic rdiv_step;
    logic out_load;
  } rsi_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic warm_done;
    logic warm_last;
    logic loss_zero;
    logic out_free;
  } rsi_sts_t;

endpackage

`default_nettype wire

### sv/rsi_if.sv
// Handshake interfaces for the price input and the RSI result channels.
// Depends on rsi_pkg for the payload widths.
`default_nettype none

interface rsi_price_if;
  logic                            valid;
  logic                            ready;
  logic [rsi_pkg::PRICE_IN_W-1:0]  price;
  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface rsi_result_if;
  logic                       valid;
  logic                       ready;
  logic [rsi_pkg::RSI_W-1:0]  strength;
  modport source (output valid, output strength, input ready);
  modport sink (input valid, input strength, output ready);
endinterface

`default_nettype wire

### sv/rsi_ctrl.sv
// Sequencer for the RSI unit: steps the datapath through warm-up, seeding,
// smoothing and the RSI quotient. Depends on rsi_pkg.
`default_nettype none

module rsi_ctrl #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire rsi_pkg::rsi_sts_t  sts_i,
  output rsi_pkg::rsi_cmd_t       cmd_o
);

  localparam int MW    = PRICE_BITS + FRAC_BITS + rsi_pkg::GUARD_BITS;
  localparam int QB    = FRAC_BITS + rsi_pkg::SCALE_BITS;
  localparam int CNT_W = $clog2(MW);

  localparam logic [CNT_W-1:0] LANE_LAST = CNT_W'(MW - 1);
  localparam logic [CNT_W-1:0] RSI_LAST  = CNT_W'(QB - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ACC  = 4'd1;
  localparam logic [3:0] ST_SEED = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ADD  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_WB   = 4'd6;
  localparam logic [3:0] ST_RMUL = 4'd7;
  localparam logic [3:0] ST_RDIV = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seed_q, seed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      seed_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      seed_q  <= seed_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    seed_d     = seed_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (!sts_i.have_prev) begin
            state_d = ST_IDLE;
          end else if (!sts_i.warm_done) begin
            state_d = ST_ACC;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.warm_last ? ST_SEED : ST_IDLE;
      end
      ST_SEED: begin
        cmd_o.seed_ld = 1'b1;
        seed_d        = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        seed_d    = 1'b0;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LANE_LAST) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        cmd_o.wb      = 1'b1;
        cmd_o.wb_seed = seed_q;
        state_d       = seed_q ? ST_IDLE : ST_RMUL;
      end
      ST_RMUL: begin
        cmd_o.rmul = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.loss_zero ? ST_OUT : ST_RDIV;
      end
      ST_RDIV: begin
        cmd_o.rdiv_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == RSI_LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/rsi_dp.sv
// Datapath of the RSI unit: price history, averages, two radix-2 lanes
// dividing by the period, the RSI divider and the output register.
// Depends on rsi_pkg.
`default_nettype none

module rsi_dp #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rsi_pkg::PERIOD_W-1:0]      cfg_wdata_i,
  input  wire [PRICE_BITS-1:0]             price_i,
  input  wire rsi_pkg::rsi_cmd_t           cmd_i,
  output rsi_pkg::rsi_sts_t                sts_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [rsi_pkg::RSI_W-1:0]        out_data_o
);

  localparam int PW = rsi_pkg::PERIOD_W;
  localparam int MW = PRICE_BITS + FRAC_BITS + rsi_pkg::GUARD_BITS;
  localparam int LW = MW + PW;
  localparam int QB = FRAC_BITS + rsi_pkg::SCALE_BITS;
  localparam int SB = rsi_pkg::SCALE_BITS;
  localparam int OW = rsi_pkg::RSI_W;

  localparam logic [QB-1:0] RSI_FULL = QB'(rsi_pkg::RSI_SCALE) << FRAC_BITS;

  // architectural state
  logic [PW-1:0]         period_q;
  logic [PRICE_BITS-1:0] prev_q;
  logic                  have_prev_q;
  logic [MW-1:0]         gain_q, loss_q;
  logic [PW-1:0]         warm_q;
  logic                  out_valid_q;

  // working registers
  logic [PRICE_BITS-1:0] up_q, dn_q;
  logic [LW-1:0]         lane_g_q, lane_l_q;
  logic [MW:0]           rr_q, sum_q;
  logic [QB-1:0]         rn_q;
  logic [OW-1:0]         out_data_q;

  logic [PW-1:0]         p_eff, pm1;
  logic [PW:0]           p9, g9, l9, gd9, ld9;
  logic                  g_ge, l_ge;
  logic [LW-1:0]         mul_g, mul_l;
  logic [MW+SB-1:0]      prod;
  logic [MW+1:0]         t_r, sum_x, diff_r;
  logic                  r_ge;
  logic [QB-1:0]         rsi_sel;
  logic [OW-1:0]         rsi_next;

  assign p_eff = (period_q < rsi_pkg::PERIOD_MIN) ? rsi_pkg::PERIOD_MIN : period_q;
  assign pm1   = p_eff - 1'b1;
  assign p9    = {1'b0, p_eff};

  assign mul_g = LW'(gain_q) * LW'(pm1);
  assign mul_l = LW'(loss_q) * LW'(pm1);

  // one restoring step per lane: remainder sits in the top PW bits
  assign g9   = {lane_g_q[LW-1:MW], lane_g_q[MW-1]};
  assign l9   = {lane_l_q[LW-1:MW], lane_l_q[MW-1]};
  assign g_ge = g9 >= p9;
  assign l_ge = l9 >= p9;
  assign gd9  = g_ge ? (g9 - p9) : g9;
  assign ld9  = l_ge ? (l9 - p9) : l9;

  assign prod   = (MW+SB)'(gain_q) * (MW+SB)'(rsi_pkg::RSI_SCALE);
  assign t_r    = {rr_q, rn_q[QB-1]};
  assign sum_x  = {1'b0, sum_q};
  assign r_ge   = t_r >= sum_x;
  assign diff_r = t_r - sum_x;

  assign rsi_sel = sts_o.loss_zero ? RSI_FULL : rn_q;

  if (QB >= OW) begin : g_out_trunc
    assign rsi_next = rsi_sel[OW-1:0];
  end else begin : g_out_ext
    assign rsi_next = {{(OW-QB){1'b0}}, rsi_sel};
  end

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.warm_done = (warm_q == rsi_pkg::WARM_DONE);
  assign sts_o.warm_last = ({1'b0, warm_q} + 1'b1) >= p9;
  assign sts_o.loss_zero = (loss_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= rsi_pkg::PERIOD_RESET;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      gain_q      <= '0;
      loss_q      <= '0;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        prev_q      <= price_i;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.acc) begin
        gain_q <= gain_q + MW'(up_q);
        loss_q <= loss_q + MW'(dn_q);
        warm_q <= warm_q + 1'b1;
      end
      if (cmd_i.wb) begin
        gain_q <= lane_g_q[MW-1:0];
        loss_q <= lane_l_q[MW-1:0];
        if (cmd_i.wb_seed) begin
          warm_q <= rsi_pkg::WARM_DONE;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      up_q <= (price_i > prev_q) ? (price_i - prev_q) : '0;
      dn_q <= (price_i > prev_q) ? '0 : (prev_q - price_i);
    end
    if (cmd_i.seed_ld) begin
      lane_g_q <= LW'(gain_q) << FRAC_BITS;
      lane_l_q <= LW'(loss_q) << FRAC_BITS;
    end else if (cmd_i.mul) begin
      lane_g_q <= mul_g;
      lane_l_q <= mul_l;
    end else if (cmd_i.add) begin
      lane_g_q <= lane_g_q + (LW'(up_q) << FRAC_BITS);
      lane_l_q <= lane_l_q + (LW'(dn_q) << FRAC_BITS);
    end else if (cmd_i.div_step) begin
      lane_g_q <= {gd9[PW-1:0], lane_g_q[MW-2:0], g_ge};
      lane_l_q <= {ld9[PW-1:0], lane_l_q[MW-2:0], l_ge};
    end
    if (cmd_i.rmul) begin
      rr_q  <= (MW+1)'(prod >> SB);
      rn_q  <= {prod[SB-1:0], {FRAC_BITS{1'b0}}};
      sum_q <= (MW+1)'(gain_q) + (MW+1)'(loss_q);
    end else if (cmd_i.rdiv_step) begin
      rr_q <= r_ge ? diff_r[MW:0] : t_r[MW:0];
      rn_q <= {rn_q[QB-2:0], r_ge};
    end
    if (cmd_i.out_load) begin
      out_data_q <= rsi_next;
    end
  end

endmodule

`default_nettype wire

### sv/relative_strength_index_unit.sv
// Relative strength index unit (Wilder smoothing), top level.
// Depends on rsi_pkg, rsi_if, rsi_ctrl and rsi_dp.
//
// Usage: prices enter on price_i (valid/ready), results leave on rsi_o as
// RSI in Q(FRAC_BITS), 0 to 100. The user must write the period register
// through cfg_we_i/cfg_wdata_i only while the unit is idle; the block does
// not enforce this. 0 and 1 act as 2. The first price is stored only; the
// next `period` prices sum gains and losses and seed the averages, without
// results. Every later price yields exactly one result.
// MW = PRICE_BITS + FRAC_BITS + 8, QB = FRAC_BITS + 7.
// The radix-2 divider lanes run MW steps for the division by the period and
// QB steps for the RSI quotient, which is skipped with no average loss.
// A result is loaded into an output register once that register is free. The
// next price is taken while that result waits; a further result waits in
// the sequencer until the output register frees up.
// Reset sets period to 14 and clears history, averages and warm-up count.
`default_nettype none

module relative_strength_index_unit #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [rsi_pkg::PERIOD_W-1:0]   cfg_wdata_i,
  rsi_price_if.sink                     price_i,
  rsi_result_if.source                  rsi_o
);

  rsi_pkg::rsi_cmd_t     cmd;
  rsi_pkg::rsi_sts_t     sts;
  logic [PRICE_BITS-1:0] price_w;
  logic                  in_ready;

  if (PRICE_BITS <= rsi_pkg::PRICE_IN_W) begin : g_price_trunc
    assign price_w = price_i.price[PRICE_BITS-1:0];
  end else begin : g_price_ext
    assign price_w = {{(PRICE_BITS-rsi_pkg::PRICE_IN_W){1'b0}}, price_i.price};
  end

  assign price_i.ready = in_ready;

  rsi_ctrl #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (price_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsi_dp #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .price_i     (price_w),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (rsi_o.valid),
    .out_ready_i (rsi_o.ready),
    .out_data_o  (rsi_o.strength)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsi_o.valid || rsi_o.ready))
    else $error("result register overwritten");

  // results only come after warm-up has finished
  a_out_after_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.warm_done)
    else $error("result during warm-up");

  // the sequencer issues at most one datapath operation per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take, cmd.acc, cmd.seed_ld, cmd.mul, cmd.add, cmd.div_step,
              cmd.wb, cmd.rmul, cmd.rdiv_step, cmd.out_load}))
    else $error("overlapping datapath commands");

  // smoothing only follows a price taken after warm-up
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |=> !cmd.mul || $past(sts.warm_done))
    else $error("smoothing started before warm-up finished");

endmodule

`default_nettype wire
